/* rtl/circular_orbit_position_top_macros.svh */
// Assertion helpers for the orbit position RTL.
`ifndef CIRCULAR_ORBIT_POSITION_TOP_MACROS_SVH
`define CIRCULAR_ORBIT_POSITION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define COP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define COP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define COP_ASSERT(lbl, clk, rstn, prop)
`define COP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* rtl/cop_pkg.sv */
package cop_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int TIME_BITS    = 40;
  localparam int CORDIC_STEPS = 28;
  localparam int CW           = 36;
  localparam int PW           = 32;
  localparam int QW           = 32;
  localparam int DIV_STAGES   = TIME_BITS + QW;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  localparam logic [16:0] EARTH_RADIUS_KM = 17'd6378;
  localparam logic [14:0] PERIOD_K_Q8     = 15'd25355;

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [CW-1:0] GAIN_Q30     = 36'sd1768195364;
  localparam logic signed [CW-1:0] HALF_TURN    = 36'sd2147483648;
  localparam logic signed [CW-1:0] QUARTER_TURN = 36'sd1073741824;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [1:0] {
    REG_ALTITUDE  = 2'd0,
    REG_START     = 2'd1,
    REG_LONGITUDE = 2'd2,
    REG_INCL      = 2'd3
  } cop_reg_e;

  typedef struct packed {
    logic [15:0] altitude_km;
    logic [31:0] start_angle;
    logic [31:0] longitude_offset;
    logic [31:0] inclination;
  } cop_cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  function automatic logic signed [CW-1:0] atan_ext(int unsigned i);
    return $signed({{(CW-32){1'b0}}, ATAN_TAB[i]});
  endfunction

  function automatic logic signed [CW-1:0] angle_ext(logic [31:0] a);
    return $signed({{(CW-32){a[31]}}, a});
  endfunction

  // Fold into +-quarter turn; the result sign flips when folded
  function automatic logic rot_neg(logic [31:0] a);
    logic signed [CW-1:0] z;
    z = angle_ext(a);
    return (z > QUARTER_TURN) || (z < -QUARTER_TURN);
  endfunction

  function automatic cordic_t rot_pre(logic [31:0] a);
    cordic_t r;
    logic signed [CW-1:0] z;
    z = angle_ext(a);
    if (z > QUARTER_TURN) begin
      z = z - HALF_TURN;
    end else if (z < -QUARTER_TURN) begin
      z = z + HALF_TURN;
    end
    r.x = INV_GAIN_Q30;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  function automatic cordic_t rot_step(cordic_t c, int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] xs, ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.z >= 0) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_ext(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_ext(i);
    end
    return r;
  endfunction

  function automatic cordic_t vec_pre(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    cordic_t r;
    if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.z = HALF_TURN;
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  function automatic cordic_t vec_step(cordic_t c, int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] xs, ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.y < 0) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_ext(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_ext(i);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] mul_q30(logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return p[CW+29:30];
  endfunction

  function automatic logic [ANGLE_BITS-1:0] out_angle(logic [31:0] a);
    logic [63:0] w;
    w = {a, 32'b0} >> (64 - ANGLE_BITS);
    return w[ANGLE_BITS-1:0];
  endfunction

endpackage

/* rtl/cop_period.sv */
module cop_period (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic [15:0]          altitude_km_i,
  output logic                 busy_o,
  output logic [cop_pkg::PW-1:0] period_o
);
  import cop_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_CUBE = 5'b00100,
    ST_K    = 5'b01000,
    ST_ROOT = 5'b10000
  } cop_per_e;

  cop_per_e    state_q, state_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] v_q, v_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] radius;
  logic [63:0] trial;
  logic [PW-1:0] per_raw;

  assign radius = {1'b0, altitude_km_i} + EARTH_RADIUS_KM;
  assign trial  = res_q + bit_q;

  // Sequence r^3*K, then one integer square root bit pair per cycle
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    v_d     = v_q;
    res_d   = res_q;
    bit_d   = bit_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: ;
      ST_SQ: begin
        acc_d   = {30'b0, {17'b0, radius} * {17'b0, radius}};
        state_d = ST_CUBE;
      end
      ST_CUBE: begin
        acc_d   = {13'b0, {17'b0, acc_q[33:0]} * {34'b0, radius}};
        state_d = ST_K;
      end
      ST_K: begin
        v_d     = {15'b0, acc_q[48:0]} * {49'b0, PERIOD_K_Q8};
        res_d   = '0;
        bit_d   = 64'h4000_0000_0000_0000;
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (v_q >= trial) begin
          v_d   = v_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (restart_i) begin
      state_d = ST_SQ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SQ;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  // Period in ms is the root over 16, never below one
  assign per_raw  = res_q[PW+3:4];
  assign period_o = (per_raw == '0) ? PW'(1) : per_raw;
  assign busy_o   = (state_q != ST_IDLE);

endmodule

/* rtl/cop_front.sv */
module cop_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         accept_i,
  input  logic [cop_pkg::TIME_BITS-1:0] elapsed_i,
  input  logic [cop_pkg::PW-1:0]       period_i,
  input  logic [31:0]                  start_angle_i,
  output logic                         valid_o,
  output logic [31:0]                  angle_o
);
  import cop_pkg::*;

  logic                 vld_q [0:DIV_STAGES];
  logic [TIME_BITS-1:0] t_q   [0:DIV_STAGES];
  logic [PW-1:0]        rem_q [0:DIV_STAGES];
  logic [QW-1:0]        quo_q [0:DIV_STAGES];

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t_q[0]   <= elapsed_i;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
    end
  end

  // Long division of elapsed*2^32 by the period, one quotient bit a stage
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [PW:0]   tr;
    logic          ge;
    logic [PW:0]   diff;

    always_comb begin
      tr   = {rem_q[k-1], t_q[k-1][TIME_BITS-1]};
      ge   = (tr >= {1'b0, period_i});
      diff = tr - {1'b0, period_i};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        t_q[k]   <= {t_q[k-1][TIME_BITS-2:0], 1'b0};
        rem_q[k] <= ge ? diff[PW-1:0] : tr[PW-1:0];
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
      end
    end
  end

  // Low quotient bits are the period fraction; add it as a phase
  assign valid_o = vld_q[DIV_STAGES];
  assign angle_o = start_angle_i + quo_q[DIV_STAGES];

endmodule

/* rtl/cop_fifo.sv */
`include "circular_orbit_position_top_macros.svh"
module cop_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [31:0] push_data_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        valid_o,
  output logic [31:0] head_o
);
  import cop_pkg::*;

  logic [31:0]        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {{FIFO_AW{1'b0}}, push_i} - {{FIFO_AW{1'b0}}, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  `COP_ASSERT(a_push_room, clk_i, rst_ni, push_i |-> !full_o)
  `COP_ASSERT(a_pop_data, clk_i, rst_ni, pop_i |-> valid_o)
  `COP_ASSERT(a_fill, clk_i, rst_ni, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
  `COP_ASSERT_NR(a_cnt_max, clk_i, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

/* rtl/cop_back.sv */
module cop_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cop_pkg::cop_cfg_t             cfg_i,
  input  logic                          head_valid_i,
  input  logic [31:0]                   head_angle_i,
  output logic                          pop_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [16:0]                   radius_km_o,
  output logic [cop_pkg::ANGLE_BITS-1:0] colatitude_o,
  output logic [cop_pkg::ANGLE_BITS-1:0] azimuth_o
);
  import cop_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic adv;

  logic    rv_q [0:N];
  cordic_t ru_q [0:N];
  cordic_t ri_q [0:N];
  logic    nu_q [0:N];
  logic    ni_q [0:N];

  logic                 m1v_q;
  logic signed [CW-1:0] s_q, c1_q, cu_q;
  logic signed [CW-1:0] su, cu, si, ci;

  logic                 v1v_q [0:N];
  cordic_t              v1_q  [0:N];
  logic signed [CW-1:0] sg_q  [0:N];

  logic                 v2v_q [0:N];
  cordic_t              v2_q  [0:N];
  logic [31:0]          az_q  [0:N];

  logic                 out_vld_q;
  logic [16:0]          rad_q;
  logic [ANGLE_BITS-1:0] col_q, azi_q;
  logic [31:0]          colat;

  // Advance the whole pipeline when the output register can take a result
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  // Fold both angles into the CORDIC range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else if (adv) begin
      rv_q[0] <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ru_q[0] <= rot_pre(head_angle_i);
      nu_q[0] <= rot_neg(head_angle_i);
      ri_q[0] <= rot_pre(cfg_i.inclination);
      ni_q[0] <= rot_neg(cfg_i.inclination);
    end
  end

  // Rotation: sine and cosine of orbit angle and inclination
  for (genvar k = 1; k <= N; k++) begin : g_rot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k] <= 1'b0;
      end else if (adv) begin
        rv_q[k] <= rv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ru_q[k] <= rot_step(ru_q[k-1], k-1);
        ri_q[k] <= rot_step(ri_q[k-1], k-1);
        nu_q[k] <= nu_q[k-1];
        ni_q[k] <= ni_q[k-1];
      end
    end
  end

  // Products sin i * sin u and cos i * sin u; s is then scaled by the CORDIC gain
  always_comb begin
    su = nu_q[N] ? -ru_q[N].y : ru_q[N].y;
    cu = nu_q[N] ? -ru_q[N].x : ru_q[N].x;
    si = ni_q[N] ? -ri_q[N].y : ri_q[N].y;
    ci = ni_q[N] ? -ri_q[N].x : ri_q[N].x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1v_q    <= 1'b0;
      v1v_q[0] <= 1'b0;
    end else if (adv) begin
      m1v_q    <= rv_q[N];
      v1v_q[0] <= m1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q     <= mul_q30(si, su);
      c1_q    <= mul_q30(ci, su);
      cu_q    <= cu;
      v1_q[0] <= vec_pre(cu_q, c1_q);
      sg_q[0] <= mul_q30(s_q, GAIN_Q30);
    end
  end

  // Vectoring of (cos u, cos i sin u): azimuth and magnitude
  for (genvar k = 1; k <= N; k++) begin : g_vec1
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1v_q[k] <= 1'b0;
      end else if (adv) begin
        v1v_q[k] <= v1v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        v1_q[k] <= vec_step(v1_q[k-1], k-1);
        sg_q[k] <= sg_q[k-1];
      end
    end
  end

  // Vectoring of (gain * s, magnitude): colatitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2v_q[0] <= 1'b0;
    end else if (adv) begin
      v2v_q[0] <= v1v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v2_q[0] <= vec_pre(sg_q[N], v1_q[N].x);
      az_q[0] <= v1_q[N].z[31:0];
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_vec2
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2v_q[k] <= 1'b0;
      end else if (adv) begin
        v2v_q[k] <= v2v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        v2_q[k] <= vec_step(v2_q[k-1], k-1);
        az_q[k] <= az_q[k-1];
      end
    end
  end

  // Clamp colatitude to zero .. half turn
  always_comb begin
    if (v2_q[N].z < 0) begin
      colat = '0;
    end else if (v2_q[N].z > HALF_TURN) begin
      colat = HALF_TURN[31:0];
    end else begin
      colat = v2_q[N].z[31:0];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= v2v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q <= {1'b0, cfg_i.altitude_km} + EARTH_RADIUS_KM;
      col_q <= out_angle(colat);
      azi_q <= out_angle(az_q[N] + cfg_i.longitude_offset);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign radius_km_o  = rad_q;
  assign colatitude_o = col_q;
  assign azimuth_o    = azi_q;

endmodule

/* rtl/circular_orbit_position_top.sv */
// Circular-orbit position: each request carries the ms elapsed since the
// elements were set and yields radius, colatitude and azimuth. One request is
// taken per cycle while in_stall_o is low; the path runs through 72 divider
// stages for the period fraction, a small queue, three 28-step CORDIC pipelines
// and the multiplies. After reset and after each altitude write the period is
// recomputed, and in_stall_o is high while that runs.
module circular_orbit_position_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cop_pkg::TIME_BITS-1:0] elapsed_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [16:0]                   radius_km_o,
  output logic [cop_pkg::ANGLE_BITS-1:0] colatitude_o,
  output logic [cop_pkg::ANGLE_BITS-1:0] azimuth_o
);
  import cop_pkg::*;

  cop_cfg_t       cfg_q;
  logic           busy;
  logic [PW-1:0]  period;
  logic           fifo_full, front_adv, front_vld, push;
  logic [31:0]    front_angle;
  logic           head_vld, pop;
  logic [31:0]    head_angle;
  logic           alt_wr;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.altitude_km      <= 16'd500;
      cfg_q.start_angle      <= '0;
      cfg_q.longitude_offset <= '0;
      cfg_q.inclination      <= '0;
    end else if (cfg_we_i) begin
      case (cop_reg_e'(cfg_idx_i))
        REG_ALTITUDE:  cfg_q.altitude_km      <= cfg_data_i[15:0];
        REG_START:     cfg_q.start_angle      <= cfg_data_i;
        REG_LONGITUDE: cfg_q.longitude_offset <= cfg_data_i;
        REG_INCL:      cfg_q.inclination      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign alt_wr = cfg_we_i && (cop_reg_e'(cfg_idx_i) == REG_ALTITUDE);

  cop_period u_period (
    .clk_i,
    .rst_ni,
    .restart_i     (alt_wr),
    .altitude_km_i (cfg_q.altitude_km),
    .busy_o        (busy),
    .period_o      (period)
  );

  // Front moves while the queue has room
  assign front_adv  = !fifo_full;
  assign in_stall_o = busy || fifo_full;
  assign push       = front_adv && front_vld;

  cop_front u_front (
    .clk_i,
    .rst_ni,
    .adv_i         (front_adv),
    .accept_i      (in_valid_i && !in_stall_o),
    .elapsed_i     (elapsed_ms_i),
    .period_i      (period),
    .start_angle_i (cfg_q.start_angle),
    .valid_o       (front_vld),
    .angle_o       (front_angle)
  );

  cop_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (front_angle),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .valid_o     (head_vld),
    .head_o      (head_angle)
  );

  cop_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .head_valid_i (head_vld),
    .head_angle_i (head_angle),
    .pop_o        (pop),
    .out_stall_i,
    .out_valid_o,
    .radius_km_o,
    .colatitude_o,
    .azimuth_o
  );

endmodule

/* verif/tb_circular_orbit_position_top.sv */
module tb_circular_orbit_position_top;
  import cop_pkg::*;

  typedef struct {
    logic [16:0] radius_km;
    logic [31:0] colatitude;
    logic [31:0] azimuth;
  } orbit_fix_t;

  // Orbit position predictor plus the queue of pending fixes
  class orbit_scoreboard;
    logic [15:0] altitude_km;
    logic [31:0] start_angle;
    logic [31:0] longitude_offset;
    logic [31:0] inclination;
    orbit_fix_t  pending_fixes[$];
    int          errors;

    function new();
      altitude_km      = 16'd500;
      start_angle      = '0;
      longitude_offset = '0;
      inclination      = '0;
      errors           = 0;
    endfunction

    function void write_reg(cop_reg_e idx, logic [31:0] data);
      case (idx)
        REG_ALTITUDE:  altitude_km = data[15:0];
        REG_START:     start_angle = data;
        REG_LONGITUDE: longitude_offset = data;
        REG_INCL:      inclination = data;
        default: ;
      endcase
    endfunction

    function longint unsigned period_ms();
      longint unsigned r, v, res, b;
      r = 64'(altitude_km) + 64'd6378;
      v = r * r * r * 64'd25355;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      res = res >> 4;
      return (res == 0) ? 64'd1 : res;
    endfunction

    // Rotation CORDIC: sine and cosine in Q30
    function void sin_cos(logic [31:0] a, output longint sn, output longint cs);
      longint z, x, y, xs, ys;
      bit neg;
      z = longint'({32'b0, a});
      x = 64'sd652032874;
      y = 0;
      neg = 0;
      if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
      if (z > 64'sd1073741824) begin
        z = z - 64'sd2147483648;
        neg = 1;
      end else if (z < -64'sd1073741824) begin
        z = z + 64'sd2147483648;
        neg = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'({32'b0, ATAN_TAB[i]});
        end else begin
          x = x + ys; y = y - xs; z = z + longint'({32'b0, ATAN_TAB[i]});
        end
      end
      sn = neg ? -y : y;
      cs = neg ? -x : x;
    endfunction

    // Vectoring CORDIC: angle and scaled magnitude
    function longint vectoring(longint x, longint y, output longint mag);
      longint z, xs, ys;
      z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd2147483648;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x = x - ys; y = y + xs; z = z - longint'({32'b0, ATAN_TAB[i]});
        end else begin
          x = x + ys; y = y - xs; z = z + longint'({32'b0, ATAN_TAB[i]});
        end
      end
      mag = x;
      return z;
    endfunction

    function void note_request(logic [TIME_BITS-1:0] elapsed);
      longint unsigned per, rem, q;
      longint su, cu, si, ci, s, c1, mag, unused_mag, az, colat;
      logic [31:0] u, az32;
      orbit_fix_t fix;
      per = period_ms();
      rem = 64'(elapsed) % per;
      q = (rem << 32) / per;
      u = start_angle + q[31:0];
      sin_cos(u, su, cu);
      sin_cos(inclination, si, ci);
      s = (si * su) >>> 30;
      c1 = (ci * su) >>> 30;
      az = vectoring(cu, c1, mag);
      colat = vectoring((s * 64'sd1768195364) >>> 30, mag, unused_mag);
      if (colat < 0) colat = 0;
      if (colat > 64'sd2147483648) colat = 64'sd2147483648;
      az32 = az[31:0] + longitude_offset;
      fix.radius_km = 17'(altitude_km) + 17'd6378;
      fix.colatitude = colat[31:0];
      fix.azimuth = az32;
      pending_fixes.push_back(fix);
    endfunction

    function void check_result(logic [16:0] radius, logic [31:0] colat, logic [31:0] az);
      orbit_fix_t exp_fix;
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result radius=%0d colat=%h az=%h", $time, radius, colat, az);
        errors++;
        return;
      end
      exp_fix = pending_fixes.pop_front();
      if (radius !== exp_fix.radius_km) begin
        $display("%0t: radius_km expected %0d got %0d", $time, exp_fix.radius_km, radius);
        errors++;
      end
      if (colat !== exp_fix.colatitude) begin
        $display("%0t: colatitude expected %h got %h", $time, exp_fix.colatitude, colat);
        errors++;
      end
      if (az !== exp_fix.azimuth) begin
        $display("%0t: azimuth expected %h got %h", $time, exp_fix.azimuth, az);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [31:0]           cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [TIME_BITS-1:0]  elapsed_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [16:0]           radius_km_o;
  logic [ANGLE_BITS-1:0] colatitude_o;
  logic [ANGLE_BITS-1:0] azimuth_o;

  orbit_scoreboard sb = new();
  int              idle_mode;  // 0: no idling, 1: short gaps, 2: heavy

  circular_orbit_position_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elapsed_ms_i (elapsed_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .radius_km_o  (radius_km_o),
    .colatitude_o (colatitude_o),
    .azimuth_o    (azimuth_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Note accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_request(elapsed_ms_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(radius_km_o, colatitude_o, azimuth_o);
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99, 0);
    if (idle_mode == 0) return 0;
    if (idle_mode == 1) return (p < 70) ? 0 : ((p < 95) ? $urandom_range(3, 1) : 0);
    return (p < 40) ? 0 : ((p < 85) ? $urandom_range(3, 1) : $urandom_range(40, 5));
  endfunction

  // Stall the result side at random, except in idle mode 0
  always @(posedge clk_i) begin
    if (idle_mode == 0) out_stall_i <= 1'b0;
    else if (idle_mode == 1) out_stall_i <= ($urandom_range(99, 0) < 15);
    else out_stall_i <= ($urandom_range(99, 0) < 45);
  end

  task automatic send_request(logic [TIME_BITS-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_ms_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_fixes.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(cop_reg_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_orbit(logic [31:0] alt, logic [31:0] start, logic [31:0] lon,
                           logic [31:0] incl);
    write_reg(REG_ALTITUDE, alt);
    write_reg(REG_START, start);
    write_reg(REG_LONGITUDE, lon);
    write_reg(REG_INCL, incl);
  endtask

  function automatic logic [TIME_BITS-1:0] random_elapsed();
    logic [63:0] w;
    longint unsigned per;
    int p;
    per = sb.period_ms();
    p = $urandom_range(99, 0);
    w = {$urandom, $urandom};
    if (p < 50) return w[TIME_BITS-1:0];
    if (p < 80) begin
      w = per * $urandom_range(5000, 0) + $urandom_range(4, 0) - 2;
      return w[TIME_BITS-1:0];
    end
    return TIME_BITS'(w % per);
  endfunction

  // Directed items at zero, the maximum and around the period boundaries
  task automatic directed_items();
    longint unsigned per;
    per = sb.period_ms();
    send_request('0);
    send_request({TIME_BITS{1'b1}});
    send_request(TIME_BITS'(per - 1));
    send_request(TIME_BITS'(per));
    send_request(TIME_BITS'(per + 1));
    send_request(TIME_BITS'(per / 4));
    send_request(TIME_BITS'(per / 2));
    send_request(TIME_BITS'(3 * per / 4));
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_ALTITUDE;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    elapsed_ms_i = '0;
    out_stall_i  = 1'b0;
    idle_mode    = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset elements, then polar and equatorial-like special cases
    directed_items();
    drain();
    set_orbit(32'd0, 32'h4000_0000, 32'h8000_0000, 32'h4000_0000);
    directed_items();
    drain();
    set_orbit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    directed_items();
    drain();

    // Random phases across several orbits, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_orbit(32'd0, 32'd0, 32'h8000_0000, 32'd0);
        1: set_orbit(32'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        2: set_orbit(32'd500, 32'h4000_0000, 32'd0, 32'hFFFF_FFFF);
        default: set_orbit($urandom, $urandom, $urandom,
                           ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(32'h8000_0000, 0));
      endcase
      idle_mode = ph % 3;
      for (int n = 0; n < 250; n++) begin
        if (ph == 4 && n == 120) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (sb.pending_fixes.size() != 0) @(posedge clk_i);
        end
        send_request(random_elapsed());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cop_pkg.sv
rtl/cop_period.sv
rtl/cop_front.sv
rtl/cop_fifo.sv
rtl/cop_back.sv
rtl/circular_orbit_position_top.sv
verif/tb_circular_orbit_position_top.sv
